// ===== hw/rtl/spq_pkg.sv =====
// shared types, constants, pointer helpers and a saturating increment for the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int PRIO_WIDTH  = 16;
  localparam int AW          = $clog2(DEPTH);
  localparam int CW          = $clog2(DEPTH + 1);

  localparam logic [PRIO_WIDTH-1:0] PRIO_MAX = '1;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] count_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_AGE    = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_RPT_RD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [PRIO_WIDTH-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    logic   a_en;
    addr_t  a_addr;
    logic   b_en;
    addr_t  b_addr;
  } store_ctl_t;

  function automatic addr_t ptr_inc(addr_t p);
    return (p == addr_t'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic addr_t ptr_dec(addr_t p);
    return (p == '0) ? addr_t'(DEPTH - 1) : p - 1'b1;
  endfunction

  // both operands below DEPTH
  function automatic addr_t ptr_add(addr_t p, addr_t n);
    logic [AW:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= (AW + 1)'(DEPTH)) s = s - (AW + 1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [PRIO_WIDTH-1:0] sat_inc(logic [PRIO_WIDTH-1:0] p);
    return (p == PRIO_MAX) ? p : p + 1'b1;
  endfunction

endpackage

// ===== hw/rtl/spq_in_if.sv =====
// request channel of the sorted priority queue: operation and new entry
// depends on spq_pkg
interface spq_in_if import spq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  op_t                    operation;
  logic [VALUE_WIDTH-1:0] item_value;
  logic [PRIO_WIDTH-1:0]  item_priority;

  modport source (output valid, operation, item_value, item_priority, input ready);
  modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

// ===== hw/rtl/spq_out_if.sv =====
// response channel of the sorted priority queue: queue status after each operation
// depends on spq_pkg
interface spq_out_if import spq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] front_value;
  logic [PRIO_WIDTH-1:0]  front_priority;
  logic [PRIO_WIDTH-1:0]  max_priority;
  count_t                 entry_total;
  logic                   is_empty;
  err_t                   error_code;

  modport source (output valid, front_value, front_priority, max_priority, entry_total,
                  is_empty, error_code, input ready);
  modport sink   (input valid, front_value, front_priority, max_priority, entry_total,
                  is_empty, error_code, output ready);
endinterface

// ===== hw/rtl/spq_store.sv =====
// entry memory: one write port, two registered read ports
// depends on spq_pkg
module spq_store import spq_pkg::*; (
  input  logic       clk,
  input  store_ctl_t ctl,
  output entry_t     a_data,
  output entry_t     b_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) mem[ctl.waddr] <= ctl.wdata;
    if (ctl.a_en) a_data <= mem[ctl.a_addr];
    if (ctl.b_en) b_data <= mem[ctl.b_addr];
  end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue of up to DEPTH (value, priority) entries, lowest priority at the
// front, equal priorities served in arrival order, but an insert equal to the front entry
// goes in front of it. Entries live in a circular buffer in a memory with one write and two
// read ports; a pop or an insert at the front only moves the head pointer. A query, pop,
// front insert, rejected operation or age of an empty queue goes from IDLE through RPT_RD
// and DONE to the output register. An insert behind the head walks back from the tail one
// entry per cycle through the memory, moving each larger entry down. Age rewrites every
// entry one per cycle. The next request is taken once the result is in the output register.
// The memory is not cleared after reset; data read outside the live window is never used.
// depends on spq_pkg, spq_in_if, spq_out_if, spq_store
module sorted_priority_queue import spq_pkg::*; (
  input logic   clk,
  input logic   rst,
  spq_in_if.sink    req,
  spq_out_if.source rsp
);

  state_t state, state_next;
  addr_t  head;
  count_t count;
  logic [VALUE_WIDTH-1:0] ins_val;
  logic [PRIO_WIDTH-1:0]  ins_pri;
  err_t   err;
  addr_t  scan_addr;
  addr_t  cmp_addr;
  logic   dv;
  count_t rd_left;
  count_t wr_left;
  logic [PRIO_WIDTH-1:0] head_pri;

  logic                   rsp_valid;
  logic [VALUE_WIDTH-1:0] front_value;
  logic [PRIO_WIDTH-1:0]  front_priority;
  logic [PRIO_WIDTH-1:0]  max_priority;
  count_t                 entry_total;
  logic                   is_empty;
  err_t                   error_code;

  store_ctl_t ctl;
  entry_t     a_data;
  entry_t     b_data;

  logic  accept;
  logic  full;
  logic  empty;
  logic  front_ins;
  logic  scan_stop;
  logic  rsp_free;
  addr_t tail_addr;

  spq_store u_store (
    .clk    (clk),
    .ctl    (ctl),
    .a_data (a_data),
    .b_data (b_data)
  );

  assign accept    = req.valid && req.ready;
  assign full      = (count == count_t'(DEPTH));
  assign empty     = (count == '0);
  assign front_ins = empty || (req.item_priority <= head_pri);
  assign scan_stop = dv && !(a_data.prio > ins_pri);
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign tail_addr = empty ? head : ptr_add(head, addr_t'(count - 1'b1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.operation)
            OP_INSERT: state_next = (full || front_ins) ? ST_RPT_RD : ST_SCAN;
            OP_AGE:    state_next = empty ? ST_RPT_RD : ST_AGE;
            default:   state_next = ST_RPT_RD;
          endcase
        end
      end
      ST_SCAN:   if (scan_stop) state_next = ST_RPT_RD;
      ST_AGE:    if (dv && wr_left == count_t'(1)) state_next = ST_RPT_RD;
      ST_RPT_RD: state_next = ST_DONE;
      ST_DONE:   if (rsp_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    ctl       = '0;
    case (state)
      ST_IDLE: begin
        if (accept && req.operation == OP_INSERT && !full && front_ins) begin
          ctl.we    = 1'b1;
          ctl.waddr = empty ? head : ptr_dec(head);
          ctl.wdata = '{value: req.item_value, prio: req.item_priority};
        end
      end
      ST_SCAN: begin
        ctl.a_en   = 1'b1;
        ctl.a_addr = scan_addr;
        // larger entries move one place toward the tail
        if (dv) begin
          ctl.we    = 1'b1;
          ctl.waddr = ptr_inc(cmp_addr);
          ctl.wdata = (a_data.prio > ins_pri) ? a_data
                                              : entry_t'{value: ins_val, prio: ins_pri};
        end
      end
      ST_AGE: begin
        ctl.a_en   = (rd_left != '0);
        ctl.a_addr = scan_addr;
        if (dv) begin
          ctl.we    = 1'b1;
          ctl.waddr = cmp_addr;
          ctl.wdata = '{value: a_data.value, prio: sat_inc(a_data.prio)};
        end
      end
      ST_RPT_RD: begin
        ctl.a_en   = 1'b1;
        ctl.a_addr = head;
        ctl.b_en   = 1'b1;
        ctl.b_addr = tail_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      dv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && rsp_free) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ins_val <= req.item_value;
            ins_pri <= req.item_priority;
            dv      <= 1'b0;
            case (req.operation)
              OP_INSERT: begin
                if (full) begin
                  err <= ERR_FULL;
                end else begin
                  err <= ERR_OK;
                  if (front_ins) begin
                    if (!empty) head <= ptr_dec(head);
                    count <= count + 1'b1;
                  end else begin
                    scan_addr <= tail_addr;
                  end
                end
              end
              OP_POP: begin
                if (empty) begin
                  err <= ERR_EMPTY;
                end else begin
                  err   <= ERR_OK;
                  head  <= ptr_inc(head);
                  count <= count - 1'b1;
                end
              end
              OP_AGE: begin
                err       <= ERR_OK;
                scan_addr <= head;
                rd_left   <= count;
                wr_left   <= count;
              end
              default: err <= ERR_OK;
            endcase
          end
        end
        ST_SCAN: begin
          dv        <= 1'b1;
          cmp_addr  <= scan_addr;
          scan_addr <= ptr_dec(scan_addr);
          if (scan_stop) count <= count + 1'b1;
        end
        ST_AGE: begin
          if (rd_left != '0) begin
            dv        <= 1'b1;
            cmp_addr  <= scan_addr;
            scan_addr <= ptr_inc(scan_addr);
            rd_left   <= rd_left - 1'b1;
          end else begin
            dv <= 1'b0;
          end
          if (dv) wr_left <= wr_left - 1'b1;
        end
        ST_DONE: begin
          if (rsp_free) begin
            head_pri <= a_data.prio;
          end
        end
        default: ;
      endcase
    end
  end

  // result payload, loaded together with rsp_valid
  always_ff @(posedge clk) begin
    if (state == ST_DONE && rsp_free) begin
      front_value    <= empty ? '0 : a_data.value;
      front_priority <= empty ? '0 : a_data.prio;
      max_priority   <= empty ? '0 : b_data.prio;
      entry_total    <= count;
      is_empty       <= empty;
      error_code     <= err;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.front_value    = front_value;
  assign rsp.front_priority = front_priority;
  assign rsp.max_priority   = max_priority;
  assign rsp.entry_total    = entry_total;
  assign rsp.is_empty       = is_empty;
  assign rsp.error_code     = error_code;

endmodule

// ===== hw/rtl/spq_checker.sv =====
// port-level checks on the queue status reported by sorted_priority_queue
// depends on spq_pkg; bound to the top level below
module spq_checker import spq_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [PRIO_WIDTH-1:0]  front_priority,
  input logic [PRIO_WIDTH-1:0]  max_priority,
  input logic [VALUE_WIDTH-1:0] front_value,
  input count_t                 entry_total,
  input logic                   is_empty,
  input err_t                   error_code
);

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_total == '0)))
    else $error("empty flag disagrees with entry count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> (front_value == '0 && front_priority == '0 &&
                               max_priority == '0))
    else $error("empty queue reports nonzero front or max");

  a_err_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((error_code != ERR_FULL || entry_total == count_t'(DEPTH)) &&
                   (error_code != ERR_EMPTY || entry_total == '0)))
    else $error("error code inconsistent with entry count");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !is_empty |-> (front_priority <= max_priority))
    else $error("front priority above max priority");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_total))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .front_priority (rsp.front_priority),
  .max_priority   (rsp.max_priority),
  .front_value    (rsp.front_value),
  .entry_total    (rsp.entry_total),
  .is_empty       (rsp.is_empty),
  .error_code     (rsp.error_code)
);

// ===== verif/tb_sorted_priority_queue.sv =====
// testbench for sorted_priority_queue: directed table then random traffic, every status
// transfer checked against a shadow queue kept in the bench or against a typed table row
// depends on spq_pkg, spq_in_if, spq_out_if and the sorted_priority_queue rtl
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 200;
  localparam int PHASE_ITEMS  = 250;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] front_value;
    logic [PRIO_WIDTH-1:0]  front_prio;
    logic [PRIO_WIDTH-1:0]  max_prio;
    count_t                 total;
    logic                   empty;
    err_t                   err;
  } status_t;

  typedef struct packed {
    op_t                    op;
    logic [VALUE_WIDTH-1:0] value;
    logic [PRIO_WIDTH-1:0]  prio;
    int                     reps;
    bit                     typed;
    status_t                want;
  } stim_row_t;

  localparam status_t EMPTY_OK = '{32'h0, 16'h0, 16'h0, 5'd0, 1'b1, ERR_OK};

  logic clk;
  logic rst;

  spq_in_if  req_if ();
  spq_out_if rsp_if ();

  sorted_priority_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  entry_t  shadow_q[$];
  status_t awaited_status[$];
  int      error_count     = 0;
  int      idle_cycles     = 0;
  int      tx_idle_pct     = 0;
  int      rx_idle_pct     = 0;
  int      hold_left       = 0;
  bit      hold_rx_request = 1'b0;

  // table walked before the random part; typed rows carry the status read off by hand
  stim_row_t directed [16] = '{
    '{OP_QUERY,  32'h0,        16'h0,    1,  1'b1, EMPTY_OK},
    '{OP_POP,    32'h0,        16'h0,    1,  1'b1, '{32'h0, 16'h0, 16'h0, 5'd0, 1'b1, ERR_EMPTY}},
    '{OP_AGE,    32'h0,        16'h0,    1,  1'b1, EMPTY_OK},
    '{OP_INSERT, 32'hFFFFFFFF, 16'hFFFF, 1,  1'b1,
      '{32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 5'd1, 1'b0, ERR_OK}},
    // priority already at the top stays there
    '{OP_AGE,    32'h0,        16'h0,    1,  1'b1,
      '{32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 5'd1, 1'b0, ERR_OK}},
    '{OP_INSERT, 32'h0,        16'h0,    1,  1'b1, '{32'h0, 16'h0, 16'hFFFF, 5'd2, 1'b0, ERR_OK}},
    // equal to the head goes in front of it
    '{OP_INSERT, 32'h1,        16'h0,    1,  1'b1, '{32'h1, 16'h0, 16'hFFFF, 5'd3, 1'b0, ERR_OK}},
    '{OP_INSERT, 32'h55,       16'h5,    1,  1'b0, EMPTY_OK},
    '{OP_INSERT, 32'h56,       16'h5,    1,  1'b0, EMPTY_OK},
    '{OP_INSERT, 32'hA5A5A5A5, 16'hFFFE, 1,  1'b0, EMPTY_OK},
    '{OP_AGE,    32'h0,        16'h0,    1,  1'b0, EMPTY_OK},
    '{OP_QUERY,  32'h0,        16'h0,    1,  1'b0, EMPTY_OK},
    '{OP_INSERT, 32'h1234,     16'h8000, 10, 1'b1,
      '{32'h1, 16'h1, 16'hFFFF, 5'd16, 1'b0, ERR_OK}},
    '{OP_INSERT, 32'h5,        16'h5,    1,  1'b1,
      '{32'h1, 16'h1, 16'hFFFF, 5'd16, 1'b0, ERR_FULL}},
    '{OP_POP,    32'h0,        16'h0,    1,  1'b0, EMPTY_OK},
    '{OP_QUERY,  32'h0,        16'h0,    1,  1'b0, EMPTY_OK}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // shadow queue: applies one operation and returns the status the block should report
  function automatic status_t apply_op(op_t op, logic [VALUE_WIDTH-1:0] value,
                                       logic [PRIO_WIDTH-1:0] prio);
    status_t st;
    entry_t  e;
    int      pos;
    st.err = ERR_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_q.size() >= DEPTH) begin
          st.err = ERR_FULL;
        end else begin
          e.value = value;
          e.prio  = prio;
          if (shadow_q.size() == 0 || prio <= shadow_q[0].prio) begin
            pos = 0;
          end else begin
            pos = shadow_q.size();
            for (int i = 0; i < shadow_q.size(); i++) begin
              if (shadow_q[i].prio > prio) begin
                pos = i;
                break;
              end
            end
          end
          shadow_q.insert(pos, e);
        end
      end
      OP_POP: begin
        if (shadow_q.size() == 0) st.err = ERR_EMPTY;
        else void'(shadow_q.pop_front());
      end
      OP_AGE: begin
        foreach (shadow_q[i])
          if (shadow_q[i].prio != PRIO_MAX) shadow_q[i].prio = shadow_q[i].prio + 1'b1;
      end
      default: ;
    endcase
    st.total = count_t'(shadow_q.size());
    if (shadow_q.size() == 0) begin
      st.front_value = '0;
      st.front_prio  = '0;
      st.max_prio    = '0;
      st.empty       = 1'b1;
    end else begin
      st.front_value = shadow_q[0].value;
      st.front_prio  = shadow_q[0].prio;
      st.max_prio    = shadow_q[shadow_q.size() - 1].prio;
      st.empty       = 1'b0;
    end
    return st;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    error_count++;
  endtask

  // offers one request, waits for its transfer and records the status to come back
  task automatic drive_op(op_t op, logic [VALUE_WIDTH-1:0] value, logic [PRIO_WIDTH-1:0] prio,
                          bit typed, status_t want);
    status_t st;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.operation     <= op;
    req_if.item_value    <= value;
    req_if.item_priority <= prio;
    do @(posedge clk); while (!req_if.ready);
    st = apply_op(op, value, prio);
    awaited_status.push_back(typed ? want : st);
  endtask

  task automatic wait_for_status_drain();
    req_if.valid <= 1'b0;
    while (awaited_status.size() != 0) @(posedge clk);
  endtask

  function automatic op_t pick_op(int mix);
    int r;
    int ins_lim;
    int pop_lim;
    int age_lim;
    r = $urandom_range(0, 99);
    case (mix)
      0:       begin ins_lim = 60; pop_lim = 75; age_lim = 90; end  // filling
      1:       begin ins_lim = 15; pop_lim = 75; age_lim = 88; end  // draining
      default: begin ins_lim = 40; pop_lim = 75; age_lim = 90; end
    endcase
    if (r < ins_lim) return OP_INSERT;
    if (r < pop_lim) return OP_POP;
    if (r < age_lim) return OP_AGE;
    return OP_QUERY;
  endfunction

  function automatic logic [PRIO_WIDTH-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    // small range makes ties, the top range makes aging saturate
    if (r < 40) return PRIO_WIDTH'($urandom_range(0, 7));
    if (r < 70) return PRIO_WIDTH'($urandom);
    if (r < 90) return PRIO_MAX - PRIO_WIDTH'($urandom_range(0, 15));
    return ($urandom_range(0, 1) != 0) ? PRIO_MAX : '0;
  endfunction

  task automatic run_phase(int tx_pct, int rx_pct, bit with_hold);
    int                     mix;
    op_t                    op;
    logic [VALUE_WIDTH-1:0] value;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    mix = 2;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 30 == 0) mix = $urandom_range(0, 2);
      if (with_hold && i == PHASE_ITEMS / 3) hold_rx_request = 1'b1;
      op = pick_op(mix);
      if ($urandom_range(0, 9) == 0) value = ($urandom_range(0, 1) != 0) ? '1 : '0;
      else value = VALUE_WIDTH'($urandom);
      drive_op(op, value, pick_prio(), 1'b0, EMPTY_OK);
    end
  endtask

  // response side: random stalls plus one long hold while requests keep coming
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx_request) begin
        hold_rx_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (awaited_status.size() == 0) begin
        report_mismatch("status with none awaited", rsp_if.front_value, '0);
      end else begin
        want = awaited_status.pop_front();
        if (rsp_if.front_value !== want.front_value)
          report_mismatch("front_value", rsp_if.front_value, want.front_value);
        if (rsp_if.front_priority !== want.front_prio)
          report_mismatch("front_priority", 32'(rsp_if.front_priority), 32'(want.front_prio));
        if (rsp_if.max_priority !== want.max_prio)
          report_mismatch("max_priority", 32'(rsp_if.max_priority), 32'(want.max_prio));
        if (rsp_if.entry_total !== want.total)
          report_mismatch("entry_total", 32'(rsp_if.entry_total), 32'(want.total));
        if (rsp_if.is_empty !== want.empty)
          report_mismatch("is_empty", 32'(rsp_if.is_empty), 32'(want.empty));
        if (rsp_if.error_code !== want.err)
          report_mismatch("error_code", 32'(rsp_if.error_code), 32'(want.err));
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst                  <= 1'b1;
    req_if.valid         <= 1'b0;
    req_if.operation     <= OP_QUERY;
    req_if.item_value    <= '0;
    req_if.item_priority <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    foreach (directed[i])
      for (int k = 0; k < directed[i].reps; k++)
        drive_op(directed[i].op, directed[i].value, directed[i].prio,
                 directed[i].typed && k == directed[i].reps - 1, directed[i].want);

    run_phase(36, 47, 1'b1);
    // sender stops until every status is back
    wait_for_status_drain();
    run_phase(47, 36, 1'b0);
    wait_for_status_drain();
    run_phase(0, 0, 1'b0);

    wait_for_status_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_status.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_in_if.sv
hw/rtl/spq_out_if.sv
hw/rtl/spq_store.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
verif/tb_sorted_priority_queue.sv
